### src/sdo_pkg.sv
// Shared types, constants and helper functions of the speed and disturbance observer.
// Used by sdo_mul, sdo_core and speed_disturbance_observer; depends on nothing.
package sdo_pkg;

    // Width of the stored observer states (Q.32 fixed point, 32 to 64 bits).
    localparam int STATE_WIDTH = 48;
    localparam int OUT_WIDTH   = 48;
    localparam int WORD_WIDTH  = 64;
    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TS          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TS_SQ_HALF  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K_ANGLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_K_DIST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_GAIN = 3'd5;

    localparam logic signed [WORD_WIDTH-1:0] TS_RESET         = 64'sd3602879701896;
    localparam logic signed [WORD_WIDTH-1:0] TS_SQ_HALF_RESET = 64'sd90071993;

    // Product scaling: coefficient products drop 56 fraction bits, the current product 40.
    localparam int SH_HI = 56;
    localparam int SH_LO = 40;

    localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam logic signed [STATE_WIDTH-1:0] ST_MAX  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] ST_MIN  = {1'b1, {(STATE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] ts;
        logic signed [WORD_WIDTH-1:0] ts_sq_half;
        logic signed [WORD_WIDTH-1:0] k_angle;
        logic signed [WORD_WIDTH-1:0] k_speed;
        logic signed [WORD_WIDTH-1:0] k_dist;
        logic signed [WORD_WIDTH-1:0] torque_gain;
    } cfg_t;

    typedef struct packed {
        logic                         start;
        logic signed [WORD_WIDTH-1:0] a;
        logic signed [WORD_WIDTH-1:0] b;
        logic                         sh_hi;
    } mul_req_t;

    typedef struct packed {
        logic                         done;
        logic signed [WORD_WIDTH-1:0] res;
        logic                         sat;
    } mul_rsp_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] err_total;
        logic [OUT_WIDTH-1:0] angle_step;
        logic [OUT_WIDTH-1:0] speed_out;
        logic [OUT_WIDTH-1:0] dist_out;
        logic                 sat_flag;
    } result_t;

    function automatic logic signed [WORD_WIDTH-1:0] st_to_word(
        input logic signed [STATE_WIDTH-1:0] x);
        return WORD_WIDTH'(x);
    endfunction

    function automatic logic [OUT_WIDTH-1:0] st_to_out(
        input logic signed [STATE_WIDTH-1:0] x);
        logic signed [WORD_WIDTH-1:0] w;
        w = WORD_WIDTH'(x);
        return w[OUT_WIDTH-1:0];
    endfunction

endpackage

### src/speed_disturbance_observer.sv
// Top level of the third-order speed and disturbance observer.
// Holds the configuration registers and the result register; depends on sdo_pkg and sdo_core.
//
// Each input transaction carries one control tick: the measured q-axis current (Q16.16) and
// the measured angle increment error (Q16.32). The block updates its four observer states
// (accumulated error, predicted angle step, speed and disturbance estimate) and returns them as
// one result transaction together with a flag that is set when any product, sum or store of
// the tick saturated. All arithmetic runs on one shared 32 x 32 multiplier and one 64-bit
// saturating adder under a sixteen-step sequencer: seven 64 x 64 products and nine adder
// steps. A new input transaction is accepted only once the previous update has committed.
// The result sits in an output register, so the next input transaction is accepted while
// the previous result still waits; an update only stalls at its final commit when that
// register is still full. Configuration registers are written through a plain write port
// and must only be changed while no update is in progress; a write to an index beyond the
// last register is ignored.
module speed_disturbance_observer import sdo_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Configuration write port.
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [WORD_WIDTH-1:0]       cfg_data,
    // Input channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_iq_current,
    input  logic signed [47:0]          s_meas_err,
    // Result channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_WIDTH-1:0] m_err_total,
    output logic signed [OUT_WIDTH-1:0] m_angle_step,
    output logic signed [OUT_WIDTH-1:0] m_speed_out,
    output logic signed [OUT_WIDTH-1:0] m_dist_out,
    output logic                        m_sat_flag
);

    cfg_t    cfg_reg, cfg_next;
    result_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;

    logic    core_idle, core_finish, out_free;
    result_t core_res;

    // The result register is free when empty or when its content leaves in this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = core_idle;

    sdo_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .start    (s_valid && core_idle),
        .iq       (s_iq_current),
        .meas     (s_meas_err),
        .out_free (out_free),
        .idle     (core_idle),
        .finish   (core_finish),
        .res      (core_res)
    );

    // Configuration registers.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TS:          cfg_next.ts          = signed'(cfg_data);
                CFG_TS_SQ_HALF:  cfg_next.ts_sq_half  = signed'(cfg_data);
                CFG_K_ANGLE:     cfg_next.k_angle     = signed'(cfg_data);
                CFG_K_SPEED:     cfg_next.k_speed     = signed'(cfg_data);
                CFG_K_DIST:      cfg_next.k_dist      = signed'(cfg_data);
                CFG_TORQUE_GAIN: cfg_next.torque_gain = signed'(cfg_data);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Result register: loaded when the core commits, cleared when the transaction is taken.
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (core_finish) begin
            out_next     = core_res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ts          <= TS_RESET;
            cfg_reg.ts_sq_half  <= TS_SQ_HALF_RESET;
            cfg_reg.k_angle     <= '0;
            cfg_reg.k_speed     <= '0;
            cfg_reg.k_dist      <= '0;
            cfg_reg.torque_gain <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_err_total  = out_reg.err_total;
    assign m_angle_step = out_reg.angle_step;
    assign m_speed_out  = out_reg.speed_out;
    assign m_dist_out   = out_reg.dist_out;
    assign m_sat_flag   = out_reg.sat_flag;

endmodule

### src/sdo_mul.sv
// Iterative signed 64 x 64 multiplier with rounding shift and saturation.
// Built on one shared 32 x 32 multiplier; depends on sdo_pkg.
module sdo_mul import sdo_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    localparam int ACC_W = 2 * WORD_WIDTH;
    localparam int HALF  = WORD_WIDTH / 2;
    localparam logic [2:0] CNT_LAST = 3'd5;

    logic [WORD_WIDTH-1:0]        x_reg, x_next, y_reg, y_next;
    logic                         neg_reg, neg_next, sh_hi_reg, sh_hi_next;
    logic [ACC_W-1:0]             acc_reg, acc_next;
    logic [WORD_WIDTH-1:0]        pp_reg, pp_next;
    logic [1:0]                   pos_reg, pos_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next, done_reg, done_next;
    logic signed [WORD_WIDTH-1:0] res_reg, res_next;
    logic                         sat_reg, sat_next;

    logic [HALF-1:0]       x_half, y_half;
    logic [ACC_W-1:0]      shifted;
    logic [WORD_WIDTH-1:0] mag_res;
    logic                  hi_nz, ovf;

    always_comb begin
        x_half  = cnt_reg[1] ? x_reg[WORD_WIDTH-1:HALF] : x_reg[HALF-1:0];
        y_half  = cnt_reg[0] ? y_reg[WORD_WIDTH-1:HALF] : y_reg[HALF-1:0];
        shifted = sh_hi_reg ? (acc_reg >> SH_HI) : (acc_reg >> SH_LO);
        hi_nz   = sh_hi_reg ? (|acc_reg[ACC_W-1:WORD_WIDTH+SH_HI])
                            : (|acc_reg[ACC_W-1:WORD_WIDTH+SH_LO]);
        mag_res = shifted[WORD_WIDTH-1:0];
        // Positive results must stay below 2^63, negative ones may reach it.
        ovf     = hi_nz | (mag_res[WORD_WIDTH-1] & (~neg_reg | (|mag_res[WORD_WIDTH-2:0])));

        x_next     = x_reg;
        y_next     = y_reg;
        neg_next   = neg_reg;
        sh_hi_next = sh_hi_reg;
        acc_next   = acc_reg;
        pp_next    = pp_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sat_next   = sat_reg;

        if (!busy_reg) begin
            if (req.start) begin
                x_next     = req.a[WORD_WIDTH-1] ? (~req.a + 1'b1) : req.a;
                y_next     = req.b[WORD_WIDTH-1] ? (~req.b + 1'b1) : req.b;
                neg_next   = req.a[WORD_WIDTH-1] ^ req.b[WORD_WIDTH-1];
                sh_hi_next = req.sh_hi;
                // Seed the accumulator with the rounding constant.
                acc_next   = req.sh_hi ? (ACC_W'(1) << (SH_HI - 1))
                                       : (ACC_W'(1) << (SH_LO - 1));
                cnt_next   = '0;
                busy_next  = 1'b1;
            end
        end else begin
            if (!cnt_reg[2]) begin
                pp_next  = WORD_WIDTH'(x_half * y_half);
                pos_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0 && cnt_reg != CNT_LAST) begin
                acc_next = acc_reg + ({{WORD_WIDTH{1'b0}}, pp_reg} << {pos_reg, 5'd0});
            end
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                sat_next  = ovf;
                if (ovf) begin
                    res_next = neg_reg ? WORD_MIN : WORD_MAX;
                end else begin
                    res_next = neg_reg ? signed'(~mag_res + 1'b1) : signed'(mag_res);
                end
            end else begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        neg_reg   <= neg_next;
        sh_hi_reg <= sh_hi_next;
        acc_reg   <= acc_next;
        pp_reg    <= pp_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
        sat_reg   <= sat_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;
    assign rsp.sat  = sat_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("multiply started while the unit is busy");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("multiply done held for more than one cycle");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == CNT_LAST) |=> (done_reg && !busy_reg))
        else $error("multiply did not finish after its last partial product");

endmodule

### src/sdo_core.sv
// Observer sequencer: step list, saturating adder, state registers and multiplier issue.
// Depends on sdo_pkg and instantiates sdo_mul.
module sdo_core import sdo_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  logic                  start,
    input  logic signed [31:0]    iq,
    input  logic signed [47:0]    meas,
    input  logic                  out_free,
    output logic                  idle,
    output logic                  finish,
    output result_t               res
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ALU      = 3'd1;
    localparam logic [2:0] S_MUL_GO   = 3'd2;
    localparam logic [2:0] S_MUL_WAIT = 3'd3;
    localparam logic [2:0] S_FIN      = 3'd4;

    localparam logic [3:0] ST_ACC_ADD = 4'd0;
    localparam logic [3:0] ST_ACC_SUB = 4'd1;
    localparam logic [3:0] ST_U_MUL   = 4'd2;
    localparam logic [3:0] ST_DU_ADD  = 4'd3;
    localparam logic [3:0] ST_AP0_MUL = 4'd4;
    localparam logic [3:0] ST_AP0_ADD = 4'd5;
    localparam logic [3:0] ST_AP1_MUL = 4'd6;
    localparam logic [3:0] ST_AP1_ADD = 4'd7;
    localparam logic [3:0] ST_AP2_MUL = 4'd8;
    localparam logic [3:0] ST_AP2_ADD = 4'd9;
    localparam logic [3:0] ST_W0_MUL  = 4'd10;
    localparam logic [3:0] ST_W0_ADD  = 4'd11;
    localparam logic [3:0] ST_W1_MUL  = 4'd12;
    localparam logic [3:0] ST_W1_ADD  = 4'd13;
    localparam logic [3:0] ST_D_MUL   = 4'd14;
    localparam logic [3:0] ST_D_ADD   = 4'd15;

    logic [2:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;
    logic       sat_reg, sat_next;

    logic signed [STATE_WIDTH-1:0] err_reg, err_next, ap_reg, ap_next;
    logic signed [STATE_WIDTH-1:0] w_reg, w_next, d_reg, d_next;
    logic signed [STATE_WIDTH-1:0] e_n_reg, e_n_next, ap_n_reg, ap_n_next;
    logic signed [STATE_WIDTH-1:0] w_n_reg, w_n_next, d_n_reg, d_n_next;
    logic signed [WORD_WIDTH-1:0]  iq_reg, iq_next, meas_reg, meas_next;
    logic signed [WORD_WIDTH-1:0]  t_reg, t_next, du_reg, du_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    logic signed [WORD_WIDTH-1:0]  alu_a, alu_b, alu_sat;
    logic                          alu_sub, alu_clamp;
    logic signed [WORD_WIDTH:0]    sum;
    logic                          ovf, fits, alu_flag;
    logic [WORD_WIDTH-STATE_WIDTH:0] top_bits;
    logic signed [STATE_WIDTH-1:0] alu_st;

    sdo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    // Operand selection for the shared adder.
    always_comb begin
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        alu_clamp = 1'b0;
        case (step_reg)
            ST_ACC_ADD: begin
                alu_a = st_to_word(err_reg);
                alu_b = meas_reg;
            end
            ST_ACC_SUB: begin
                alu_a     = t_reg;
                alu_b     = st_to_word(ap_reg);
                alu_sub   = 1'b1;
                alu_clamp = 1'b1;
            end
            ST_DU_ADD: begin
                alu_a = st_to_word(d_reg);
                alu_b = mrsp.res;
            end
            ST_AP0_ADD: begin
                alu_b = mrsp.res;
            end
            ST_AP1_ADD: begin
                alu_a = t_reg;
                alu_b = mrsp.res;
            end
            ST_AP2_ADD, ST_W1_ADD: begin
                alu_a     = t_reg;
                alu_b     = mrsp.res;
                alu_clamp = 1'b1;
            end
            ST_W0_ADD: begin
                alu_a = st_to_word(w_reg);
                alu_b = mrsp.res;
            end
            ST_D_ADD: begin
                alu_a     = st_to_word(d_reg);
                alu_b     = mrsp.res;
                alu_clamp = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase

        sum      = alu_sub ? ((WORD_WIDTH+1)'(alu_a) - (WORD_WIDTH+1)'(alu_b))
                           : ((WORD_WIDTH+1)'(alu_a) + (WORD_WIDTH+1)'(alu_b));
        ovf      = sum[WORD_WIDTH] != sum[WORD_WIDTH-1];
        alu_sat  = ovf ? (sum[WORD_WIDTH] ? WORD_MIN : WORD_MAX) : sum[WORD_WIDTH-1:0];
        top_bits = alu_sat[WORD_WIDTH-1:STATE_WIDTH-1];
        fits     = (&top_bits) | (~|top_bits);
        alu_st   = fits ? alu_sat[STATE_WIDTH-1:0]
                        : (alu_sat[WORD_WIDTH-1] ? ST_MIN : ST_MAX);
        alu_flag = ovf | (alu_clamp & ~fits);
    end

    // Multiplier operands for each multiply step.
    always_comb begin
        mreq.start = (state_reg == S_MUL_GO);
        mreq.a     = '0;
        mreq.b     = '0;
        mreq.sh_hi = 1'b1;
        case (step_reg)
            ST_U_MUL: begin
                mreq.a     = iq_reg;
                mreq.b     = cfg.torque_gain;
                mreq.sh_hi = 1'b0;
            end
            ST_AP0_MUL: begin
                mreq.a = cfg.ts;
                mreq.b = st_to_word(w_reg);
            end
            ST_AP1_MUL: begin
                mreq.a = cfg.ts_sq_half;
                mreq.b = du_reg;
            end
            ST_AP2_MUL: begin
                mreq.a = cfg.k_angle;
                mreq.b = st_to_word(e_n_reg);
            end
            ST_W0_MUL: begin
                mreq.a = cfg.ts;
                mreq.b = du_reg;
            end
            ST_W1_MUL: begin
                mreq.a = cfg.k_speed;
                mreq.b = st_to_word(e_n_reg);
            end
            ST_D_MUL: begin
                mreq.a = cfg.k_dist;
                mreq.b = st_to_word(e_n_reg);
            end
            default: begin
                mreq.a = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        sat_next   = sat_reg;
        err_next   = err_reg;
        ap_next    = ap_reg;
        w_next     = w_reg;
        d_next     = d_reg;
        e_n_next   = e_n_reg;
        ap_n_next  = ap_n_reg;
        w_n_next   = w_n_reg;
        d_n_next   = d_n_reg;
        iq_next    = iq_reg;
        meas_next  = meas_reg;
        t_next     = t_reg;
        du_next    = du_reg;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    iq_next    = WORD_WIDTH'(iq);
                    meas_next  = WORD_WIDTH'(meas);
                    sat_next   = 1'b0;
                    step_next  = ST_ACC_ADD;
                    state_next = S_ALU;
                end
            end
            S_ALU: begin
                sat_next = sat_reg | alu_flag;
                case (step_reg)
                    ST_ACC_SUB: e_n_next  = alu_st;
                    ST_DU_ADD:  du_next   = alu_sat;
                    ST_AP2_ADD: ap_n_next = alu_st;
                    ST_W1_ADD:  w_n_next  = alu_st;
                    ST_D_ADD:   d_n_next  = alu_st;
                    default:    t_next    = alu_sat;
                endcase
                if (step_reg == ST_D_ADD) begin
                    state_next = S_FIN;
                end else begin
                    step_next  = step_reg + 4'd1;
                    state_next = (step_reg == ST_ACC_ADD) ? S_ALU : S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mrsp.done) begin
                    sat_next   = sat_reg | mrsp.sat;
                    step_next  = step_reg + 4'd1;
                    state_next = S_ALU;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    err_next   = e_n_reg;
                    ap_next    = ap_n_reg;
                    w_next     = w_n_reg;
                    d_next     = d_n_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= ST_ACC_ADD;
            sat_reg   <= 1'b0;
            err_reg   <= '0;
            ap_reg    <= '0;
            w_reg     <= '0;
            d_reg     <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sat_reg   <= sat_next;
            err_reg   <= err_next;
            ap_reg    <= ap_next;
            w_reg     <= w_next;
            d_reg     <= d_next;
        end
        e_n_reg  <= e_n_next;
        ap_n_reg <= ap_n_next;
        w_n_reg  <= w_n_next;
        d_n_reg  <= d_n_next;
        iq_reg   <= iq_next;
        meas_reg <= meas_next;
        t_reg    <= t_next;
        du_reg   <= du_next;
    end

    assign idle   = (state_reg == S_IDLE);
    assign finish = (state_reg == S_FIN) && out_free;

    assign res.err_total  = st_to_out(e_n_reg);
    assign res.angle_step = st_to_out(ap_n_reg);
    assign res.speed_out  = st_to_out(w_n_reg);
    assign res.dist_out   = st_to_out(d_n_reg);
    assign res.sat_flag   = sat_reg;

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> (state_reg == S_MUL_WAIT))
        else $error("multiplier result arrived while the sequencer was not waiting");

    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (state_reg == S_IDLE))
        else $error("transaction started while an update is in progress");

    a_commit_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> (state_reg == S_IDLE && err_reg == $past(e_n_reg)))
        else $error("state commit did not return the sequencer to idle");

endmodule

### tb/tb_top.sv
// Self-checking testbench for speed_disturbance_observer: directed and random control ticks,
// predicted by a bit-exact observer model kept in the testbench and compared per result field.
// Depends on sdo_pkg and the observer RTL only.
`timescale 1ns / 1ps

module tb_top;
    import sdo_pkg::*;

    localparam int    CLK_PERIOD        = 10;
    localparam int    RESET_CYCLES      = 5;
    // Wait after the last result has drained; covers one whole update with a margin on top.
    localparam int    LATENCY_CYCLES    = 80;
    localparam int    LONG_STALL_CYCLES = 600;
    localparam int    RANDOM_PHASES     = 6;
    localparam int    TICKS_PER_PHASE   = 280;
    localparam int    PRESSURE_TICKS    = 12;
    // Even with every sender gap at its longest a correct run stays under 4 ms; the limit is
    // several times that.
    localparam longint RUN_LIMIT_NS     = 64'd20_000_000;

    // Indexes past the last register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic signed [31:0] IQ_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] IQ_MIN   = 32'sh8000_0000;
    localparam logic signed [47:0] MEAS_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MEAS_MIN = 48'sh8000_0000_0000;
    // Q8.56 value of 2^-17: a current of one LSB then yields exactly half an output LSB.
    localparam logic signed [63:0] HALF_LSB_GAIN = 64'sh0000_0080_0000_0000;
    localparam logic signed [63:0] UNITY_GAIN    = 64'sh0100_0000_0000_0000;

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [WORD_WIDTH-1:0]       cfg_data     = '0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic signed [31:0]          s_iq_current = '0;
    logic signed [47:0]          s_meas_err   = '0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic signed [OUT_WIDTH-1:0] m_err_total;
    logic signed [OUT_WIDTH-1:0] m_angle_step;
    logic signed [OUT_WIDTH-1:0] m_speed_out;
    logic signed [OUT_WIDTH-1:0] m_dist_out;
    logic                        m_sat_flag;

    // Percentages of idle cycles on each side; changed between test phases.
    int sender_idle_pct   = 22;
    int receiver_idle_pct = 55;

    // A long hold-off on the result side is requested by bumping stall_req; the receiver
    // process notices the change and counts the stretch down itself.
    int stall_req  = 0;
    int stall_seen = 0;
    int stall_left = 0;

    int error_count = 0;

    // Observer states and gains as the testbench believes them to be.
    cfg_t                    gain_model;
    logic signed [63:0]      est_err_sum, est_angle_pred, est_speed, est_dist;
    logic                    tick_sat;
    result_t                 predicted_states[$];

    speed_disturbance_observer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_iq_current (s_iq_current),
        .s_meas_err   (s_meas_err),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_err_total  (m_err_total),
        .m_angle_step (m_angle_step),
        .m_speed_out  (m_speed_out),
        .m_dist_out   (m_dist_out),
        .m_sat_flag   (m_sat_flag)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------------------------
    // Observer prediction. Values passed between steps are 64-bit signed; every clamp that
    // engages marks the tick as saturated.
    // ------------------------------------------------------------------------------------

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] wa, wb, s;
        wa = a;
        wb = b;
        s  = wa + wb;
        if (s[64] != s[63]) begin
            tick_sat = 1'b1;
            return s[64] ? WORD_MIN : WORD_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] wa, wb, s;
        wa = a;
        wb = b;
        s  = wa - wb;
        if (s[64] != s[63]) begin
            tick_sat = 1'b1;
            return s[64] ? WORD_MIN : WORD_MAX;
        end
        return s[63:0];
    endfunction

    // Exact product, then shifted right by sh with rounding to nearest and ties away from
    // zero (done on the magnitude), then clamped to the 64-bit range.
    function automatic logic signed [63:0] scale_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b,
                                                         input int sh);
        logic signed [127:0] wa, wb, p;
        logic [127:0]        magnitude, q, lim;
        logic                neg;
        wa = a;
        wb = b;
        p  = wa * wb;
        neg       = p[127];
        magnitude = neg ? -p : p;
        q         = (magnitude + (128'd1 << (sh - 1))) >> sh;
        lim       = neg ? 128'h8000_0000_0000_0000 : 128'h7FFF_FFFF_FFFF_FFFF;
        if (q > lim) begin
            tick_sat = 1'b1;
            return neg ? WORD_MIN : WORD_MAX;
        end
        return neg ? -q[63:0] : q[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_to_state(input logic signed [63:0] v);
        logic signed [63:0] top, bottom;
        top    = ST_MAX;
        bottom = ST_MIN;
        if (v > top) begin
            tick_sat = 1'b1;
            return top;
        end
        if (v < bottom) begin
            tick_sat = 1'b1;
            return bottom;
        end
        return v;
    endfunction

    // One observer tick: advances the predicted states and returns the expected result.
    function automatic result_t observer_update(input logic signed [31:0] iq,
                                                input logic signed [47:0] meas);
        logic signed [63:0] iq_w, meas_w, accel, err, dist_accel, angle, speed, dist_upd;
        result_t            r;
        iq_w     = iq;
        meas_w   = meas;
        tick_sat = 1'b0;

        accel      = scale_product(iq_w, gain_model.torque_gain, SH_LO);
        err        = clamp_to_state(sat_sub(sat_add(est_err_sum, meas_w), est_angle_pred));
        dist_accel = sat_add(est_dist, accel);

        // The angle and speed updates use the speed and disturbance of the previous tick.
        angle = sat_add(scale_product(gain_model.ts, est_speed, SH_HI),
                        scale_product(gain_model.ts_sq_half, dist_accel, SH_HI));
        angle = clamp_to_state(sat_add(angle, scale_product(gain_model.k_angle, err, SH_HI)));

        speed = sat_add(est_speed, scale_product(gain_model.ts, dist_accel, SH_HI));
        speed = clamp_to_state(sat_add(speed, scale_product(gain_model.k_speed, err, SH_HI)));

        dist_upd = clamp_to_state(sat_add(est_dist,
                                          scale_product(gain_model.k_dist, err, SH_HI)));

        est_err_sum    = err;
        est_angle_pred = angle;
        est_speed      = speed;
        est_dist       = dist_upd;

        r.err_total  = err[OUT_WIDTH-1:0];
        r.angle_step = angle[OUT_WIDTH-1:0];
        r.speed_out  = speed[OUT_WIDTH-1:0];
        r.dist_out   = dist_upd[OUT_WIDTH-1:0];
        r.sat_flag   = tick_sat;
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------------------

    // Random value spread over +/- 2^(bits-1), sign-extended to 64 bits.
    function automatic logic signed [63:0] rand_signed(input int bits);
        logic signed [63:0] r;
        r = {$urandom, $urandom};
        return r >>> (64 - bits);
    endfunction

    // Gains for a random phase. The tame set keeps the error loop stable (angle gain near
    // one, small speed and disturbance gains) so that the states wander rather than sit at
    // the rails; the wild set draws every register over its full range.
    function automatic cfg_t random_gains(input logic wild);
        cfg_t g;
        if (wild) begin
            g.ts          = rand_signed(64);
            g.ts_sq_half  = rand_signed(64);
            g.k_angle     = rand_signed(64);
            g.k_speed     = rand_signed(64);
            g.k_dist      = rand_signed(64);
            g.torque_gain = rand_signed(64);
        end else begin
            g.ts          = TS_RESET + rand_signed(38);
            g.ts_sq_half  = TS_SQ_HALF_RESET + rand_signed(24);
            g.k_angle     = UNITY_GAIN + rand_signed(56);
            g.k_speed     = rand_signed(52);
            g.k_dist      = rand_signed(48);
            g.torque_gain = rand_signed(60);
        end
        return g;
    endfunction

    // Waits until every predicted result has come back. The valid is dropped first, and in
    // a step of its own, so that a following transaction raises it at a later edge.
    task automatic settle_ticks();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_states.size() != 0)
            @(posedge aclk);
    endtask

    // Drives one register write and mirrors it in the model; the caller lowers the enable
    // once its batch of writes is done.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            CFG_TS:          gain_model.ts          = value;
            CFG_TS_SQ_HALF:  gain_model.ts_sq_half  = value;
            CFG_K_ANGLE:     gain_model.k_angle     = value;
            CFG_K_SPEED:     gain_model.k_speed     = value;
            CFG_K_DIST:      gain_model.k_dist      = value;
            CFG_TORQUE_GAIN: gain_model.torque_gain = value;
            default: ;
        endcase
    endtask

    // Registers may only change while no update is in flight, hence the settle first.
    task automatic load_gains(input cfg_t g);
        settle_ticks();
        write_reg(CFG_TS, g.ts);
        write_reg(CFG_TS_SQ_HALF, g.ts_sq_half);
        write_reg(CFG_K_ANGLE, g.k_angle);
        write_reg(CFG_K_SPEED, g.k_speed);
        write_reg(CFG_K_DIST, g.k_dist);
        write_reg(CFG_TORQUE_GAIN, g.torque_gain);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one control tick and records its predicted result once the transaction is
    // taken. Besides the per-cycle idling, an occasional long gap lets the next transaction
    // land at any point of the block's update sequence.
    task automatic send_tick(input logic signed [31:0] iq, input logic signed [47:0] meas);
        int gap;
        gap = ($urandom_range(799) < sender_idle_pct) ? $urandom_range(140, 1) : 0;
        while (gap > 0 || $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            if (gap > 0)
                gap--;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_iq_current <= iq;
        s_meas_err   <= meas;
        do
            @(posedge aclk);
        while (!s_ready);
        predicted_states.push_back(observer_update(iq, meas));
    endtask

    // Mostly realistic currents and angle errors, with a share drawn over the full field
    // width so that every input bit is exercised.
    task automatic send_random_tick();
        logic signed [31:0] iq;
        logic signed [47:0] meas;
        int                 pick;
        iq   = ($urandom_range(99) < 70) ? 32'(rand_signed(20)) : 32'(rand_signed(32));
        pick = $urandom_range(99);
        if (pick < 70)
            meas = 48'(rand_signed(30));
        else if (pick < 90)
            meas = 48'(rand_signed(40));
        else
            meas = 48'(rand_signed(48));
        send_tick(iq, meas);
    endtask

    // ------------------------------------------------------------------------------------
    // Result side: ready generation and checking.
    // ------------------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (stall_seen != stall_req) begin
            stall_seen <= stall_req;
            stall_left <= LONG_STALL_CYCLES;
            m_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Every accepted result transaction is matched against the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_states.size() == 0) begin
                $error("result transaction arrived with no update outstanding");
                error_count++;
            end else begin
                want = predicted_states.pop_front();
                compare_field("err_total", want.err_total, m_err_total);
                compare_field("angle_step", want.angle_step, m_angle_step);
                compare_field("speed_out", want.speed_out, m_speed_out);
                compare_field("dist_out", want.dist_out, m_dist_out);
                compare_field("sat_flag", 48'(want.sat_flag), 48'(m_sat_flag));
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------------------

    // Reset gains leave only the error accumulator moving. Drive it into both rails and
    // back to zero, with the current at its extremes (ignored while the torque gain is zero).
    task automatic test_reset_values();
        send_tick('0, '0);
        send_tick(IQ_MAX, MEAS_MAX);
        send_tick(IQ_MIN, MEAS_MAX);     // accumulator clamps at the top
        send_tick('0, MEAS_MIN);         // back to -1
        send_tick('0, MEAS_MIN);
        send_tick('0, MEAS_MIN);         // accumulator clamps at the bottom
        send_tick(-32'sd1, MEAS_MAX);    // back to -1
        send_tick(32'sd1, 48'sd1);       // and to zero
    endtask

    // Writes past the last register must not disturb any gain.
    task automatic test_spare_index();
        settle_ticks();
        write_reg(CFG_IDX_SPARE_LO, {$urandom, $urandom});
        write_reg(CFG_IDX_SPARE_HI, {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
        send_tick(32'sd65536, 48'sd4294967296);
        send_tick(-32'sd65536, -48'sd4294967296);
    endtask

    // Current products that fall exactly half-way between two output codes round away
    // from zero in both signs.
    task automatic test_rounding_ties();
        cfg_t g;
        g             = gain_model;
        g.torque_gain = HALF_LSB_GAIN;
        load_gains(g);
        send_tick(32'sd1, '0);
        send_tick(-32'sd1, '0);
        send_tick(32'sd3, '0);
        send_tick(-32'sd3, '0);
    endtask

    // Random phases over the three idling patterns; the last phase uses unbounded gains.
    task automatic test_random_tracking();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 2) begin
                sender_idle_pct   = 22;
                receiver_idle_pct = 55;
            end else if (phase < 4) begin
                sender_idle_pct   = 55;
                receiver_idle_pct = 22;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            load_gains(random_gains(phase == RANDOM_PHASES - 1));
            repeat (TICKS_PER_PHASE)
                send_random_tick();
        end
    endtask

    // The receiver holds off for a long stretch while ticks keep coming: the output register
    // fills, the next update stalls at its commit and the input channel stops accepting.
    task automatic test_output_backpressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        load_gains(random_gains(1'b0));
        stall_req++;
        repeat (PRESSURE_TICKS)
            send_random_tick();
    endtask

    // Every register at its positive and then its negative extreme, so that products, sums
    // and stores all saturate.
    task automatic test_extreme_gains();
        cfg_t g;
        g = '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX};
        load_gains(g);
        send_tick(IQ_MAX, MEAS_MAX);
        send_tick(IQ_MIN, MEAS_MIN);
        send_tick('0, '0);
        send_tick(IQ_MAX, MEAS_MIN);
        g = '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};
        load_gains(g);
        send_tick(IQ_MAX, MEAS_MAX);
        send_tick(IQ_MIN, MEAS_MIN);
        send_tick('0, '0);
        send_tick(IQ_MIN, MEAS_MAX);
    endtask

    initial begin
        gain_model     = '{TS_RESET, TS_SQ_HALF_RESET, '0, '0, '0, '0};
        est_err_sum    = '0;
        est_angle_pred = '0;
        est_speed      = '0;
        est_dist       = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_spare_index();
        test_rounding_ties();
        test_random_tracking();
        test_output_backpressure();
        test_extreme_gains();

        // Let the last results drain, then give any stray transaction time to show up.
        settle_ticks();
        repeat (LATENCY_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $error("run did not complete in time, %0d results outstanding", predicted_states.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
